### hdl/vtpg_pkg.sv
// ----------------------------------------------------------------------------
// vtpg_pkg
// Shared widths, register indexes and the beat type of the pattern pipeline.
// ----------------------------------------------------------------------------
package vtpg_pkg;

    localparam int COORD_W  = 10;
    localparam int BLK_W    = 10;
    localparam int REP_W    = 11;
    localparam int RING_W   = 11;
    localparam int SQ_W     = 2 * COORD_W;
    localparam int SUM_W    = 2 * COORD_W + 2;
    localparam int ROOT_W   = COORD_W + 1;
    localparam int SREM_W   = ROOT_W + 2;
    localparam int DIV_W    = (ROOT_W > REP_W) ? ROOT_W : REP_W;
    localparam int LANES    = 4;
    localparam int CFG_W    = (COORD_W > REP_W) ? COORD_W : REP_W;
    localparam int CFG_IDX_W = 3;

    // division lanes: shell remainder plus one checkerboard lane per axis
    localparam int LANE_MOD = 0;
    localparam int LANE_X   = 1;
    localparam int LANE_Y   = 2;
    localparam int LANE_Z   = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BLOCK_LENGTH      = 3'd0,
        REG_REPETITION_LENGTH = 3'd1,
        REG_RING_WIDTH        = 3'd2,
        REG_CENTER_X          = 3'd3,
        REG_CENTER_Y          = 3'd4,
        REG_CENTER_Z          = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [COORD_W-1:0]              x;
        logic [COORD_W-1:0]              y;
        logic [COORD_W-1:0]              z;
        logic [COORD_W-1:0]              dx;
        logic [COORD_W-1:0]              dy;
        logic [COORD_W-1:0]              dz;
        logic [SQ_W-1:0]                 sqx;
        logic [SQ_W-1:0]                 sqy;
        logic [SQ_W-1:0]                 sqz;
        logic [SUM_W-1:0]                sum;
        logic [ROOT_W-1:0]               root;
        logic [SREM_W-1:0]               srem;
        logic [LANES-1:0][DIV_W-1:0]     dvd;
        logic [LANES-1:0][DIV_W-1:0]     drem;
        logic [LANES-1:0]                qbit;
    } t_pay;

endpackage

### hdl/vtpg_front.sv
// ----------------------------------------------------------------------------
// vtpg_front
// Three-stage front end: axis distances, squares, squared distance.
// ----------------------------------------------------------------------------
module vtpg_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [vtpg_pkg::COORD_W-1:0] i_x,
    input  logic [vtpg_pkg::COORD_W-1:0] i_y,
    input  logic [vtpg_pkg::COORD_W-1:0] i_z,
    input  logic [vtpg_pkg::COORD_W-1:0] i_cx,
    input  logic [vtpg_pkg::COORD_W-1:0] i_cy,
    input  logic [vtpg_pkg::COORD_W-1:0] i_cz,
    output logic                    o_valid,
    input  logic                    i_ready,
    output vtpg_pkg::t_pay          o_pay
);
    import vtpg_pkg::*;

    logic r_va, r_vb, r_vc;
    t_pay r_pa, r_pb, r_pc;
    t_pay n_pa, n_pb, n_pc;
    logic rdy_a, rdy_b, rdy_c;

    assign rdy_c   = !r_vc || i_ready;
    assign rdy_b   = !r_vb || rdy_c;
    assign rdy_a   = !r_va || rdy_b;
    assign o_ready = rdy_a;
    assign o_valid = r_vc;
    assign o_pay   = r_pc;

    always_comb begin
        n_pa    = '0;
        n_pa.x  = i_x;
        n_pa.y  = i_y;
        n_pa.z  = i_z;
        n_pa.dx = (i_x >= i_cx) ? (i_x - i_cx) : (i_cx - i_x);
        n_pa.dy = (i_y >= i_cy) ? (i_y - i_cy) : (i_cy - i_y);
        n_pa.dz = (i_z >= i_cz) ? (i_z - i_cz) : (i_cz - i_z);
    end

    always_comb begin
        n_pb     = r_pa;
        n_pb.sqx = SQ_W'(r_pa.dx) * SQ_W'(r_pa.dx);
        n_pb.sqy = SQ_W'(r_pa.dy) * SQ_W'(r_pa.dy);
        n_pb.sqz = SQ_W'(r_pa.dz) * SQ_W'(r_pa.dz);
    end

    always_comb begin
        n_pc     = r_pb;
        n_pc.sum = SUM_W'(r_pb.sqx) + SUM_W'(r_pb.sqy) + SUM_W'(r_pb.sqz);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else begin
            if (rdy_a) r_va <= i_valid;
            if (rdy_b) r_vb <= r_va;
            if (rdy_c) r_vc <= r_vb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_a && i_valid) r_pa <= n_pa;
        if (rdy_b && r_va)    r_pb <= n_pb;
        if (rdy_c && r_vb)    r_pc <= n_pc;
    end

endmodule

### hdl/vtpg_sqrt_cell.sv
// ----------------------------------------------------------------------------
// vtpg_sqrt_cell
// One restoring square root step: two radicand bits in, one root bit out.
// ----------------------------------------------------------------------------
module vtpg_sqrt_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  vtpg_pkg::t_pay i_pay,
    output logic           o_valid,
    input  logic           i_ready,
    output vtpg_pkg::t_pay o_pay
);
    import vtpg_pkg::*;

    logic                r_valid;
    t_pay                r_pay;
    t_pay                n_pay;
    logic [SREM_W+1:0]   cand;
    logic [SREM_W+1:0]   trial;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_pay   = r_pay;

    always_comb begin
        n_pay     = i_pay;
        cand      = {i_pay.srem, i_pay.sum[SUM_W-1 -: 2]};
        trial     = (SREM_W+2)'({i_pay.root, 2'b01});
        n_pay.sum = {i_pay.sum[SUM_W-3:0], 2'b00};
        if (cand >= trial) begin
            n_pay.srem = SREM_W'(cand - trial);
            n_pay.root = {i_pay.root[ROOT_W-2:0], 1'b1};
        end else begin
            n_pay.srem = cand[SREM_W-1:0];
            n_pay.root = {i_pay.root[ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) r_pay <= n_pay;
    end

endmodule

### hdl/vtpg_div_cell.sv
// ----------------------------------------------------------------------------
// vtpg_div_cell
// One restoring division step on every lane: one quotient bit per lane.
// ----------------------------------------------------------------------------
module vtpg_div_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [vtpg_pkg::LANES-1:0][vtpg_pkg::DIV_W-1:0] i_divisor,
    input  logic           i_valid,
    output logic           o_ready,
    input  vtpg_pkg::t_pay i_pay,
    output logic           o_valid,
    input  logic           i_ready,
    output vtpg_pkg::t_pay o_pay
);
    import vtpg_pkg::*;

    logic               r_valid;
    t_pay               r_pay;
    t_pay               n_pay;
    logic [DIV_W:0]     cand [LANES];

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_pay   = r_pay;

    always_comb begin
        n_pay = i_pay;
        for (int l = 0; l < LANES; l++) begin
            cand[l]       = {i_pay.drem[l], i_pay.dvd[l][DIV_W-1]};
            n_pay.dvd[l]  = {i_pay.dvd[l][DIV_W-2:0], 1'b0};
            if (cand[l] >= {1'b0, i_divisor[l]}) begin
                n_pay.drem[l] = DIV_W'(cand[l] - {1'b0, i_divisor[l]});
                n_pay.qbit[l] = 1'b1;
            end else begin
                n_pay.drem[l] = cand[l][DIV_W-1:0];
                n_pay.qbit[l] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) r_pay <= n_pay;
    end

endmodule

### hdl/voxel_test_pattern_generator.sv
// ----------------------------------------------------------------------------
// voxel_test_pattern_generator
// Checkerboard / concentric shell test pattern, one voxel per beat.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_ready with i_voxel_x, i_voxel_y, i_voxel_z.
// Output channel: o_out_valid / i_out_ready with o_pattern_bit and
// o_pattern_active, one result beat per input beat, in order.
// Configuration: i_cfg_wr_en writes i_cfg_data to register i_cfg_index
// (0 block_length, 1 repetition_length, 2 ring_width, 3..5 center x/y/z);
// other indexes are dropped. Write only while the pipeline is empty.
// The pipeline is three front stages (distance, squares, sum), one chain
// cell per root bit, and one chain cell per quotient bit of the shared
// divider that serves the shell modulo and the three checkerboard tile
// divisions. Throughput is one beat per cycle while the receiver is ready.
// Every cell has its own valid bit and takes a new beat whenever it is
// empty or its neighbor moves, so a stalled receiver fills the chain before
// o_in_ready drops, and bubbles collapse.
// Reset clears all valid bits and the configuration registers to 0 (pattern inactive).
// ----------------------------------------------------------------------------
module voxel_test_pattern_generator (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [vtpg_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [vtpg_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [vtpg_pkg::COORD_W-1:0]   i_voxel_x,
    input  logic [vtpg_pkg::COORD_W-1:0]   i_voxel_y,
    input  logic [vtpg_pkg::COORD_W-1:0]   i_voxel_z,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_pattern_bit,
    output logic                           o_pattern_active
);
    import vtpg_pkg::*;

    logic [BLK_W-1:0]   r_block_length;
    logic [REP_W-1:0]   r_repetition_length;
    logic [RING_W-1:0]  r_ring_width;
    logic [COORD_W-1:0] r_center_x;
    logic [COORD_W-1:0] r_center_y;
    logic [COORD_W-1:0] r_center_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_length      <= '0;
            r_repetition_length <= '0;
            r_ring_width        <= '0;
            r_center_x          <= '0;
            r_center_y          <= '0;
            r_center_z          <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_BLOCK_LENGTH:      r_block_length      <= i_cfg_data[BLK_W-1:0];
                REG_REPETITION_LENGTH: r_repetition_length <= i_cfg_data[REP_W-1:0];
                REG_RING_WIDTH:        r_ring_width        <= i_cfg_data[RING_W-1:0];
                REG_CENTER_X:          r_center_x          <= i_cfg_data[COORD_W-1:0];
                REG_CENTER_Y:          r_center_y          <= i_cfg_data[COORD_W-1:0];
                REG_CENTER_Z:          r_center_z          <= i_cfg_data[COORD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // front end
    logic f_valid, f_ready;
    t_pay f_pay;

    vtpg_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_x     (i_voxel_x),
        .i_y     (i_voxel_y),
        .i_z     (i_voxel_z),
        .i_cx    (r_center_x),
        .i_cy    (r_center_y),
        .i_cz    (r_center_z),
        .o_valid (f_valid),
        .i_ready (f_ready),
        .o_pay   (f_pay)
    );

    // square root chain
    logic s_valid [ROOT_W+1];
    logic s_ready [ROOT_W+1];
    t_pay s_pay   [ROOT_W+1];

    always_comb begin
        s_pay[0]      = f_pay;
        s_pay[0].root = '0;
        s_pay[0].srem = '0;
    end
    assign s_valid[0] = f_valid;
    assign f_ready    = s_ready[0];

    for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt
        vtpg_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (s_valid[g]),
            .o_ready (s_ready[g]),
            .i_pay   (s_pay[g]),
            .o_valid (s_valid[g+1]),
            .i_ready (s_ready[g+1]),
            .o_pay   (s_pay[g+1])
        );
    end

    // divider chain: ceiling root modulo period, and tile index per axis
    logic d_valid [DIV_W+1];
    logic d_ready [DIV_W+1];
    t_pay d_pay   [DIV_W+1];
    logic [LANES-1:0][DIV_W-1:0] divisor;

    assign divisor[LANE_MOD] = DIV_W'(r_repetition_length);
    assign divisor[LANE_X]   = DIV_W'(r_block_length);
    assign divisor[LANE_Y]   = DIV_W'(r_block_length);
    assign divisor[LANE_Z]   = DIV_W'(r_block_length);

    always_comb begin
        d_pay[0]              = s_pay[ROOT_W];
        d_pay[0].drem         = '0;
        d_pay[0].qbit         = '0;
        // round up when the root is not exact
        d_pay[0].dvd[LANE_MOD] = DIV_W'(s_pay[ROOT_W].root)
                               + DIV_W'(s_pay[ROOT_W].srem != '0);
        d_pay[0].dvd[LANE_X]  = DIV_W'(s_pay[ROOT_W].x);
        d_pay[0].dvd[LANE_Y]  = DIV_W'(s_pay[ROOT_W].y);
        d_pay[0].dvd[LANE_Z]  = DIV_W'(s_pay[ROOT_W].z);
    end
    assign d_valid[0]      = s_valid[ROOT_W];
    assign s_ready[ROOT_W] = d_ready[0];

    for (genvar g = 0; g < DIV_W; g++) begin : g_div
        vtpg_div_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_divisor (divisor),
            .i_valid   (d_valid[g]),
            .o_ready   (d_ready[g]),
            .i_pay     (d_pay[g]),
            .o_valid   (d_valid[g+1]),
            .i_ready   (d_ready[g+1]),
            .o_pay     (d_pay[g+1])
        );
    end

    assign o_out_valid    = d_valid[DIV_W];
    assign d_ready[DIV_W] = i_out_ready;

    logic chk_bit, shell_bit;
    // last quotient bit is the tile index parity; an even parity sum sets the bit
    assign chk_bit   = ~(d_pay[DIV_W].qbit[LANE_X] ^ d_pay[DIV_W].qbit[LANE_Y]
                         ^ d_pay[DIV_W].qbit[LANE_Z]);
    assign shell_bit = (d_pay[DIV_W].drem[LANE_MOD] < DIV_W'(r_ring_width)) ||
                       (r_ring_width > RING_W'(DIV_W'(r_ring_width)));

    always_comb begin
        if (r_block_length != '0) begin
            o_pattern_bit = chk_bit;
        end else if (r_repetition_length != '0) begin
            o_pattern_bit = shell_bit;
        end else begin
            o_pattern_bit = 1'b0;
        end
    end

    assign o_pattern_active = (r_block_length != '0) || (r_repetition_length != '0);

endmodule

### dv/tb_voxel_test_pattern_generator.sv
// ----------------------------------------------------------------------------
// tb_voxel_test_pattern_generator
// Checkerboard and shell pattern checks against an in-bench predictor.
// Directed corners per setting, then random voxels under several
// configurations, with random idling on both channels.
// ----------------------------------------------------------------------------
class pattern_scoreboard;
    bit   exp_bit[$];
    bit   exp_active[$];
    int   n_err;

    logic [9:0]  blk_len;
    logic [10:0] rep_len;
    logic [10:0] ring;
    logic [9:0]  cx, cy, cz;

    function void reset_regs();
        blk_len = '0; rep_len = '0; ring = '0; cx = '0; cy = '0; cz = '0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [10:0] data);
        case (idx)
            vtpg_pkg::REG_BLOCK_LENGTH:      blk_len = data[9:0];
            vtpg_pkg::REG_REPETITION_LENGTH: rep_len = data;
            vtpg_pkg::REG_RING_WIDTH:        ring = data;
            vtpg_pkg::REG_CENTER_X:          cx = data[9:0];
            vtpg_pkg::REG_CENTER_Y:          cy = data[9:0];
            vtpg_pkg::REG_CENTER_Z:          cz = data[9:0];
            default: ;
        endcase
    endfunction

    // smallest root with root*root >= d
    function longint unsigned root_up(longint unsigned d);
        longint unsigned r;
        r = 0;
        for (int b = 17; b >= 0; b--)
            if (((r | (64'd1 << b)) * (r | (64'd1 << b))) <= d) r = r | (64'd1 << b);
        if (r * r < d) r++;
        return r;
    endfunction

    function void note_voxel(logic [9:0] x, logic [9:0] y, logic [9:0] z);
        longint unsigned dist2, c, ax, ay, az;
        bit b, a;
        b = 0; a = 0;
        if (blk_len != 0) begin
            b = (((x / blk_len) & 1) == 0) ^ (((y / blk_len) & 1) == 0)
                ^ (((z / blk_len) & 1) == 0);
            a = 1;
        end else if (rep_len != 0) begin
            ax = (x >= cx) ? x - cx : cx - x;
            ay = (y >= cy) ? y - cy : cy - y;
            az = (z >= cz) ? z - cz : cz - z;
            dist2 = ax * ax + ay * ay + az * az;
            c = root_up(dist2);
            b = (c % rep_len) < ring;
            a = 1;
        end
        exp_bit.push_back(b);
        exp_active.push_back(a);
    endfunction

    task report(string msg);
        $display("ERROR: %s", msg);
        n_err++;
    endtask

    task check_pattern(bit b, bit a);
        bit eb, ea;
        if (exp_bit.size() == 0) begin
            report("result beat with nothing expected");
            return;
        end
        eb = exp_bit.pop_front();
        ea = exp_active.pop_front();
        if (b !== eb)
            report($sformatf("pattern_bit %0b expected %0b", b, eb));
        if (a !== ea)
            report($sformatf("pattern_active %0b expected %0b", a, ea));
    endtask
endclass

module tb_voxel_test_pattern_generator;
    import vtpg_pkg::*;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_wr_en;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]  i_cfg_data;
    logic              i_in_valid;
    logic              o_in_ready;
    logic [COORD_W-1:0] i_voxel_x, i_voxel_y, i_voxel_z;
    logic              o_out_valid;
    logic              i_out_ready;
    logic              o_pattern_bit;
    logic              o_pattern_active;

    pattern_scoreboard sb;
    bit                calm;

    voxel_test_pattern_generator DUT (.*);

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #60000000;
        $display("CHECKS FAILED");
        $finish;
    end

    // receiver side: random stall bursts, checks every accepted beat
    initial begin
        int stall;
        i_out_ready = 0;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                sb.check_pattern(o_pattern_bit, o_pattern_active);
            end
            if (stall > 0) begin
                stall--;
                i_out_ready <= 0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(1, 3) - 1;
                i_out_ready <= 0;
            end else begin
                i_out_ready <= 1;
            end
        end
    end

    task automatic write_cfg(t_reg_idx idx, logic [CFG_W-1:0] data);
        i_cfg_wr_en <= 1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_wr_en <= 0;
        sb.write_reg(idx, data);
    endtask

    task automatic wait_drained();
        while (sb.exp_bit.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic set_mode(logic [9:0] bl, logic [10:0] rl, logic [10:0] rw,
                            logic [9:0] x, logic [9:0] y, logic [9:0] z);
        wait_drained();
        write_cfg(REG_BLOCK_LENGTH, CFG_W'(bl));
        write_cfg(REG_REPETITION_LENGTH, rl);
        write_cfg(REG_RING_WIDTH, rw);
        write_cfg(REG_CENTER_X, CFG_W'(x));
        write_cfg(REG_CENTER_Y, CFG_W'(y));
        write_cfg(REG_CENTER_Z, CFG_W'(z));
    endtask

    // one beat; valid held from its raise until accepted
    task automatic send_voxel(logic [9:0] x, logic [9:0] y, logic [9:0] z);
        if (!calm && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid <= 1;
        i_voxel_x  <= x;
        i_voxel_y  <= y;
        i_voxel_z  <= z;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_voxel(x, y, z);
    endtask

    task automatic idle_in();
        i_in_valid <= 0;
    endtask

    task automatic random_voxels(int n);
        for (int i = 0; i < n; i++)
            send_voxel(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                       10'($urandom_range(0, 1023)));
        idle_in();
    endtask

    task automatic random_shell(int n);
        logic [9:0] bx, by, bz;
        bx = sb.cx; by = sb.cy; bz = sb.cz;
        // half of the voxels near the center so small roots occur
        for (int i = 0; i < n; i++)
            if ($urandom_range(0, 1))
                send_voxel(10'(bx + $urandom_range(0, 40) - 20),
                           10'(by + $urandom_range(0, 40) - 20),
                           10'(bz + $urandom_range(0, 40) - 20));
            else
                send_voxel(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                           10'($urandom_range(0, 1023)));
        idle_in();
    endtask

    initial begin
        sb = new();
        sb.reset_regs();
        calm = 0;
        i_rst_n = 0;
        i_cfg_wr_en = 0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_in_valid = 0;
        i_voxel_x = '0;
        i_voxel_y = '0;
        i_voxel_z = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // inactive after reset
        send_voxel(0, 0, 0);
        send_voxel(1023, 1023, 1023);
        idle_in();
        // checkerboard extremes, tile 1 and 1023
        set_mode(1, 5, 2, 0, 0, 0);
        send_voxel(0, 0, 0);
        send_voxel(1, 0, 0);
        send_voxel(1023, 1022, 1);
        idle_in();
        set_mode(1023, 0, 0, 0, 0, 0);
        send_voxel(1022, 1023, 0);
        send_voxel(1023, 1023, 1023);
        idle_in();
        // shell corners, far corner, wide ring, zero ring
        set_mode(0, 2047, 2047, 0, 0, 0);
        send_voxel(0, 0, 0);
        send_voxel(1023, 1023, 1023);
        idle_in();
        set_mode(0, 7, 2047, 1023, 1023, 1023);
        send_voxel(0, 0, 0);
        send_voxel(500, 3, 1023);
        idle_in();
        set_mode(0, 1, 0, 512, 512, 512);
        send_voxel(512, 512, 512);
        send_voxel(513, 512, 512);
        idle_in();
        set_mode(0, 10, 3, 512, 512, 512);
        send_voxel(512, 512, 512);
        send_voxel(515, 516, 512);
        send_voxel(514, 513, 512);
        idle_in();
        // out of range index dropped
        wait_drained();
        i_cfg_wr_en <= 1;
        i_cfg_index <= 3'd7;
        i_cfg_data  <= 11'h7FF;
        @(posedge i_clk);
        i_cfg_index <= 3'd6;
        @(posedge i_clk);
        i_cfg_wr_en <= 0;
        send_voxel(512, 512, 512);
        idle_in();

        // random phases
        for (int p = 0; p < 12; p++) begin
            if (p % 3 == 0)
                set_mode(10'(($urandom_range(1, 1023) >> $urandom_range(0, 9)) | 1),
                         11'($urandom_range(0, 2047)), 11'($urandom_range(0, 2047)),
                         10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                         10'($urandom_range(0, 1023)));
            else
                set_mode(10'd0,
                         11'(($urandom_range(1, 2047) >> $urandom_range(0, 10)) | 1),
                         11'($urandom_range(0, 2047) >> $urandom_range(0, 10)),
                         10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                         10'($urandom_range(0, 1023)));
            if (p == 6) begin
                // hold off until the pipeline has delivered everything
                random_shell(40);
                while (sb.exp_bit.size() != 0) @(posedge i_clk);
            end
            if (sb.blk_len != 0) random_voxels(120);
            else random_shell(120);
        end
        set_mode(0, 0, 0, 0, 0, 0);
        random_voxels(30);
        calm = 1;
        set_mode(0, 13, 6, 300, 700, 100);
        random_shell(130);

        while (sb.exp_bit.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (sb.n_err == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
